/* rtl/hhbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhbp_pkg
// Shared types and constants for the http header byte parser.
// ----------------------------------------------------------------------------
package hhbp_pkg;

  localparam logic [7:0]  ChCr    = 8'h0d;
  localparam logic [7:0]  ChLf    = 8'h0a;
  localparam logic [7:0]  ChColon = 8'h3a;
  localparam logic [7:0]  ChSpace = 8'h20;

  localparam logic [15:0] CountMax      = 16'hffff;
  localparam logic [15:0] LimitResetVal = 16'd255;

  typedef enum logic [9:0] {
    StStart = 10'b00_0000_0001,
    StKey   = 10'b00_0000_0010,
    StColon = 10'b00_0000_0100,
    StSpace = 10'b00_0000_1000,
    StValue = 10'b00_0001_0000,
    StCr    = 10'b00_0010_0000,
    StLf    = 10'b00_0100_0000,
    StEndCr = 10'b00_1000_0000,
    StEnd   = 10'b01_0000_0000,
    StError = 10'b10_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    RoleSkip     = 4'd0,
    RoleKey      = 4'd1,
    RoleColon    = 4'd2,
    RoleSpace    = 4'd3,
    RoleValue    = 4'd4,
    RoleLineCr   = 4'd5,
    RoleLineLf   = 4'd6,
    RoleEndCr    = 4'd7,
    RoleEndLf    = 4'd8,
    RoleAfterEnd = 4'd9,
    RoleErrByte  = 4'd10,
    RoleAfterErr = 4'd11
  } role_e;

  typedef struct packed {
    logic [15:0] value_length;
    logic [15:0] key_length;
    role_e       role;
    logic [7:0]  byte_echo;
    logic        line_done;
    logic        block_done;
    logic        parse_error;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_word_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CountMax) ? CountMax : v + 16'd1;
  endfunction

endpackage

/* rtl/hhbp_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhbp_in_reg
// Input register stage holding one received word until the parser takes it.
// ----------------------------------------------------------------------------
module hhbp_in_reg import hhbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_word_t word_i,
  output logic     valid_o,
  input  logic     ready_i,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q, word_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (ready_o) begin
      valid_d = valid_i;
      word_d  = word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* rtl/hhbp_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhbp_fsm
// Byte classifier state machine with key and value counters.
// ----------------------------------------------------------------------------
module hhbp_fsm import hhbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_word_t    word_i,
  input  logic [15:0] limit_i,
  output result_t     res_o
);

  state_e      state_q, state_d, state_cur;
  logic [15:0] key_q, key_d, key_cur;
  logic [15:0] voff_q, voff_d, voff_cur, voff_inc;
  logic [7:0]  b;

  assign b         = word_i.data_byte;
  assign state_cur = word_i.first ? StStart : state_q;
  assign key_cur   = word_i.first ? 16'd0 : key_q;
  assign voff_cur  = word_i.first ? 16'd0 : voff_q;
  assign voff_inc  = sat_inc(voff_cur);

  always_comb begin
    state_d            = state_cur;
    key_d              = key_cur;
    voff_d             = voff_cur;
    res_o              = '0;
    res_o.byte_echo    = b;
    res_o.role         = RoleSkip;
    unique case (state_cur)
      StStart: begin
        if (b != ChCr && b != ChLf) begin
          state_d    = StKey;
          key_d      = 16'd1;
          res_o.role = RoleKey;
        end
      end
      StKey: begin
        if (b == ChColon) begin
          state_d    = StColon;
          res_o.role = RoleColon;
        end else if (b == ChCr || b == ChLf) begin
          state_d    = StError;
          res_o.role = RoleErrByte;
        end else begin
          key_d      = sat_inc(key_cur);
          res_o.role = RoleKey;
        end
      end
      StColon: begin
        if (b == ChSpace) begin
          state_d    = StSpace;
          res_o.role = RoleSpace;
        end else begin
          state_d    = StError;
          res_o.role = RoleErrByte;
        end
      end
      StSpace: begin
        state_d    = StValue;
        voff_d     = 16'd0;
        res_o.role = RoleValue;
      end
      StValue: begin
        voff_d = voff_inc;
        if (b == ChCr) begin
          state_d    = StCr;
          res_o.role = RoleLineCr;
        end else if (voff_inc > limit_i) begin
          state_d    = StError;
          res_o.role = RoleErrByte;
        end else begin
          res_o.role = RoleValue;
        end
      end
      StCr: begin
        if (b == ChLf) begin
          state_d            = StLf;
          res_o.role         = RoleLineLf;
          res_o.line_done    = 1'b1;
          res_o.key_length   = key_cur;
          res_o.value_length = voff_cur;
        end else begin
          state_d    = StError;
          res_o.role = RoleErrByte;
        end
      end
      StLf: begin
        if (b == ChCr) begin
          state_d    = StEndCr;
          res_o.role = RoleEndCr;
        end else begin
          state_d    = StKey;
          key_d      = 16'd1;
          res_o.role = RoleKey;
        end
      end
      StEndCr: begin
        if (b == ChLf) begin
          state_d          = StEnd;
          res_o.role       = RoleEndLf;
          res_o.block_done = 1'b1;
        end else begin
          state_d    = StError;
          res_o.role = RoleErrByte;
        end
      end
      StEnd: begin
        res_o.role = RoleAfterEnd;
      end
      default: begin
        state_d    = StError;
        res_o.role = RoleAfterErr;
      end
    endcase
    res_o.parse_error = (state_d == StError);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
      key_q   <= 16'd0;
      voff_q  <= 16'd0;
    end else if (step_i) begin
      state_q <= state_d;
      key_q   <= key_d;
      voff_q  <= voff_d;
    end
  end

endmodule

/* rtl/hhbp_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhbp_out_reg
// Result register holding one classified word until the sink takes it.
// ----------------------------------------------------------------------------
module hhbp_out_reg import hhbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t res_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = valid_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* rtl/http_header_byte_parser.sv */
// path: input register, combinational state update, result register
// throughput: one byte per cycle unless the result sink stalls; the per-byte
// state update is byte compares and a 16-bit counter step between the registers
// reset: parser returns to the start state, counters clear, value offset
// limit returns to 255; no clearing pass
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_byte_parser
// Classifies each byte of an http header block and reports line lengths.
// ----------------------------------------------------------------------------
module http_header_byte_parser import hhbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // value_offset_limit
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i, // data_byte
  input  logic        s_axis_tuser_i, // first
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o, // byte_echo, role, key_length, value_length, zero pad
  output logic [1:0]  m_axis_tuser_o, // line_done, parse_error
  output logic        m_axis_tlast_o  // block_done
);

  logic [15:0] limit_q;
  in_word_t    in_word, stage_word;
  logic        stage_valid, stage_ready;
  result_t     res_comb, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitResetVal;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign in_word.data_byte = s_axis_tdata_i;
  assign in_word.first     = s_axis_tuser_i;

  hhbp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .word_i  (in_word),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .word_o  (stage_word)
  );

  hhbp_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (stage_valid && stage_ready),
    .word_i  (stage_word),
    .limit_i (limit_q),
    .res_o   (res_comb)
  );

  hhbp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (stage_ready),
    .res_i   (res_comb),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = {4'b0000, res_out.value_length, res_out.key_length,
                           res_out.role, res_out.byte_echo};
  assign m_axis_tuser_o = {res_out.parse_error, res_out.line_done};
  assign m_axis_tlast_o = res_out.block_done;

endmodule

/* tb/http_header_byte_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_byte_parser_tb
// Self-checking bench for the header byte parser. Header blocks, well-formed
// and corrupted, are streamed in byte by byte with random gaps on both sides,
// under several value offset limits. Each result word is checked field by
// field against an in-bench model of the parser state machine.
// ----------------------------------------------------------------------------
module http_header_byte_parser_tb;
  import hhbp_pkg::*;

  localparam int CycleLimit = 400000;

  class hdr_scoreboard;
    state_e      st;
    logic [15:0] key_cnt;
    logic [15:0] val_off;
    logic [15:0] limit;
    result_t     expq[$];
    int          errors;
    int          lines;
    int          blocks;
    int          bad_bytes;

    function new();
      st      = StStart;
      key_cnt = '0;
      val_off = '0;
      limit   = LimitResetVal;
      errors  = 0;
      lines   = 0;
      blocks  = 0;
      bad_bytes = 0;
    endfunction

    function void set_limit(input logic [15:0] v);
      limit = v;
    endfunction

    function int pending();
      return expq.size();
    endfunction

    function void note_input(input logic [7:0] b, input logic f);
      result_t r;
      role_e   rl;
      logic [15:0] kl;
      logic [15:0] vl;
      logic ld;
      logic bd;
      kl = '0;
      vl = '0;
      ld = 1'b0;
      bd = 1'b0;
      if (f) begin
        st      = StStart;
        key_cnt = '0;
        val_off = '0;
      end
      case (st)
        StStart: begin
          if (b == ChCr || b == ChLf) begin
            rl = RoleSkip;
          end else begin
            st = StKey;
            key_cnt = 16'd1;
            rl = RoleKey;
          end
        end
        StKey: begin
          if (b == ChColon) begin
            st = StColon;
            rl = RoleColon;
          end else if (b == ChCr || b == ChLf) begin
            st = StError;
            rl = RoleErrByte;
          end else begin
            if (key_cnt != CountMax) key_cnt = key_cnt + 16'd1;
            rl = RoleKey;
          end
        end
        StColon: begin
          if (b == ChSpace) begin
            st = StSpace;
            rl = RoleSpace;
          end else begin
            st = StError;
            rl = RoleErrByte;
          end
        end
        StSpace: begin
          st = StValue;
          val_off = '0;
          rl = RoleValue;
        end
        StValue: begin
          if (val_off != CountMax) val_off = val_off + 16'd1;
          if (b == ChCr) begin
            st = StCr;
            rl = RoleLineCr;
          end else if (val_off > limit) begin
            st = StError;
            rl = RoleErrByte;
          end else begin
            rl = RoleValue;
          end
        end
        StCr: begin
          if (b == ChLf) begin
            st = StLf;
            rl = RoleLineLf;
            ld = 1'b1;
            kl = key_cnt;
            vl = val_off;
          end else begin
            st = StError;
            rl = RoleErrByte;
          end
        end
        StLf: begin
          if (b == ChCr) begin
            st = StEndCr;
            rl = RoleEndCr;
          end else begin
            st = StKey;
            key_cnt = 16'd1;
            rl = RoleKey;
          end
        end
        StEndCr: begin
          if (b == ChLf) begin
            st = StEnd;
            rl = RoleEndLf;
            bd = 1'b1;
          end else begin
            st = StError;
            rl = RoleErrByte;
          end
        end
        StEnd: begin
          rl = RoleAfterEnd;
        end
        default: begin
          st = StError;
          rl = RoleAfterErr;
        end
      endcase
      r.byte_echo    = b;
      r.role         = rl;
      r.key_length   = kl;
      r.value_length = vl;
      r.line_done    = ld;
      r.block_done   = bd;
      r.parse_error  = (st == StError);
      lines  += ld;
      blocks += bd;
      bad_bytes += (rl == RoleErrByte);
      expq.push_back(r);
    endfunction

    function void compare(input string name, input int unsigned exp_v,
                          input int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(input logic [47:0] d, input logic [1:0] u,
                               input logic l);
      result_t e;
      if (expq.size() == 0) begin
        $error("unexpected result word, byte_echo %0h", d[7:0]);
        errors++;
        return;
      end
      e = expq.pop_front();
      compare("byte_echo", e.byte_echo, d[7:0]);
      compare("role", e.role, d[11:8]);
      compare("key_length", e.key_length, d[27:12]);
      compare("value_length", e.value_length, d[43:28]);
      compare("line_done", e.line_done, u[0]);
      compare("parse_error", e.parse_error, u[1]);
      compare("block_done", e.block_done, l);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [15:0] cfg_data;
  logic        s_valid;
  logic        s_axis_tready_o;
  logic [7:0]  s_data;          // data_byte
  logic        s_user;          // first
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [47:0] m_axis_tdata_o;  // byte_echo, role, key_length, value_length, zero pad
  logic [1:0]  m_axis_tuser_o;  // line_done, parse_error
  logic        m_axis_tlast_o;  // block_done

  hdr_scoreboard sb;
  int          items_sent;
  int          cycles;
  int          in_idle_pct;
  int          out_idle_pct;
  bit          hold_req;
  int          hold_left;
  logic [15:0] limit_now;

  http_header_byte_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_ready   = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic f);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= f;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(b, f);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_text(input string s, input logic f);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], f && (i == 0));
    end
  endtask

  task automatic write_limit(input logic [15:0] v);
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(v);
    limit_now = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte(input bit key_safe);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChCr || (key_safe && (c == ChLf || c == ChColon)));
    return c;
  endfunction

  // one header block, mostly well formed, now and then with a stray byte
  task automatic send_block();
    logic [7:0] q[$];
    int nlines;
    int klen;
    int vlen;
    int cap;
    repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? ChCr : ChLf);
    nlines = $urandom_range(1, 4);
    for (int n = 0; n < nlines; n++) begin
      klen = $urandom_range(1, 8);
      repeat (klen) q.push_back(rand_byte(1'b1));
      q.push_back(ChColon);
      q.push_back(ChSpace);
      cap = (limit_now < 8) ? limit_now + 2 : 8;
      vlen = $urandom_range(0, cap);
      if (limit_now <= 400 && $urandom_range(0, 59) == 0) begin
        vlen = limit_now - 1 + $urandom_range(0, 3);
      end
      for (int i = 0; i < vlen; i++) begin
        if (i == 0 && $urandom_range(0, 5) == 0) begin
          q.push_back($urandom_range(0, 1) ? ChCr : ChLf);
        end else begin
          q.push_back(rand_byte(1'b0));
        end
      end
      q.push_back(ChCr);
      q.push_back(ChLf);
    end
    q.push_back(ChCr);
    q.push_back(ChLf);
    repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0) begin
      q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (q[i]) push_byte(q[i], i == 0);
  endtask

  task automatic run_random(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
      end else begin
        send_block();
      end
    end
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_valid      = 1'b0;
    s_data       = '0;
    s_user       = 1'b0;
    items_sent   = 0;
    cycles       = 0;
    in_idle_pct  = 38;
    out_idle_pct = 38;
    hold_req     = 1'b0;
    limit_now    = LimitResetVal;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // colon as first key byte after a line, cr as first value byte, after end
    push_text("Ky: v\015\012:: \015\015\012\015\012x", 1'b1);
    // skipped lf, cr inside a key, then sticky error
    push_text("\012a\015z", 1'b1);
    push_text("k: ", 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    // lf as first key byte after a line, then cr in the key
    push_text("\015\012\012\015", 1'b0);

    run_random(230);

    write_limit(16'd1);
    hold_req = 1'b1;
    run_random(230);

    write_limit(16'hffff);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(230);
    in_idle_pct  = 38;
    out_idle_pct = 38;

    write_limit(16'($urandom_range(2, 20)));
    run_random(230);

    write_limit(16'($urandom_range(100, 400)));
    run_random(200);

    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d result words never arrived", sb.pending());
      sb.errors++;
    end

    $display("run: %0d bytes under five value offset limits (reset, 1, max, two random)",
             items_sent);
    $display("     %0d header lines, %0d header blocks, %0d error bytes",
             sb.lines, sb.blocks, sb.bad_bytes);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
